// ----- sv/dogf_pkg.sv -----
// dogf_pkg: shared constants, types and weight functions of the difference of
// gaussians filter unit
// depends on nothing; used by every module of the unit
`default_nettype none
package dogf_pkg;

  localparam int BIG_RADIUS     = 13;
  localparam int SMALL_RADIUS   = 6;
  localparam int KER            = (BIG_RADIUS > SMALL_RADIUS) ? BIG_RADIUS : SMALL_RADIUS;
  localparam int WIN            = 2 * KER + 1;
  localparam int LROWS          = 2 * KER;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CFG_W          = 12;
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 18;
  localparam int PROD_W         = COEF_W + PIX_W + 1;
  localparam int ACC_W          = 36;
  localparam int DOG_W          = 25;
  localparam int ROW_W          = 12;
  localparam int MAX_ROW        = 4095;

  typedef logic [WIN-1:0][PIX_W-1:0] pix_vec_t;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // exp(-d*d/6.48) in q0.24
  function automatic longint tap_e(input int d);
    longint v;
    case (d)
      0:       v = 64'd16777216;
      1:       v = 64'd14378022;
      2:       v = 64'd9049756;
      3:       v = 64'd4183434;
      4:       v = 64'd1420326;
      5:       v = 64'd354161;
      6:       v = 64'd64859;
      7:       v = 64'd8724;
      8:       v = 64'd862;
      9:       v = 64'd63;
      10:      v = 64'd3;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic longint s_sum(input int radius, input int step);
    longint s;
    s = tap_e(0);
    for (int d = 1; d <= radius; d++) begin
      s = s + 2 * tap_e(d * step);
    end
    return s;
  endfunction

  localparam longint S_BIG   = s_sum(BIG_RADIUS, 1);
  localparam longint S_SMALL = s_sum(SMALL_RADIUS, 2);

  function automatic longint g_big(input int d);
    return ((tap_e(d) << 24) + S_BIG / 2) / S_BIG;
  endfunction

  function automatic longint g_small(input int d);
    return ((tap_e(2 * d) << 24) + S_SMALL / 2) / S_SMALL;
  endfunction

  function automatic longint w2d(input longint ga, input longint gb);
    return (ga * gb + (64'd1 << (47 - COEF_FRAC_BITS))) >> (48 - COEF_FRAC_BITS);
  endfunction

  // combined signed weight: small kernel minus big kernel
  function automatic logic signed [COEF_W-1:0] dog_coef(input int r, input int c);
    int a;
    int b;
    longint ws;
    longint wb;
    a = (r >= KER) ? r - KER : KER - r;
    b = (c >= KER) ? c - KER : KER - c;
    ws = 0;
    wb = 0;
    if (a <= SMALL_RADIUS && b <= SMALL_RADIUS) begin
      ws = w2d(g_small(a), g_small(b));
    end
    if (a <= BIG_RADIUS && b <= BIG_RADIUS) begin
      wb = w2d(g_big(a), g_big(b));
    end
    return COEF_W'(ws - wb);
  endfunction

endpackage
`default_nettype wire

// ----- sv/difference_of_gaussians_filter_unit.sv -----
// difference_of_gaussians_filter_unit: top level, counters, line store, row of
// column cells and output saturation; depends on dogf_pkg, dogf_line_buffer, dogf_cell
//
// Takes one 8-bit pixel per clock in raster order unless the output stalls, and
// returns one result per pixel: the small minus large gaussian blur of the
// pixel 13 rows and 13 columns back, saturated, 16 fractional bits, and zero
// with interior low near any frame edge. The unstalled rate of one pixel per
// cycle is set by the line store, which is read at one address and written back
// at another in the same cycle, and by the row of 27 column cells that each add
// their weighted column into a running sum passed to the next cell. The line
// store needs no clearing pass after reset. Frame size is to be written by the
// user only while the unit is idle; the unit itself does not enforce this.
`default_nettype none
module difference_of_gaussians_filter_unit import dogf_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [PIX_W-1:0]  pixel_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [DOG_W-1:0] dog_value_o,
  output logic                   interior_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > CFG_W) ? WW : CFG_W;
  localparam logic signed [ACC_W-1:0] DOG_LIM = ACC_W'(255 * (1 << COEF_FRAC_BITS));

  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [EW-1:0]    eff_w, col_ext;
  logic [ROW_W-1:0] eff_h;
  logic             interior;

  logic en, accept;
  logic va_q, vb_q, vc_q, out_valid_q;
  logic ins_a_q, ins_b_q, ins_c_q, interior_q;
  logic [PIX_W-1:0] pix_q;
  logic [CW-1:0]    addr_q;
  logic [LROWS*PIX_W-1:0] rd_data, wr_data;
  logic signed [DOG_W-1:0] dog_q;
  logic signed [ACC_W-1:0] sat;

  pix_vec_t  col_vec;
  cell_ctl_t cell_ctl;
  logic signed [ACC_W-1:0] acc [WIN+1];

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_W'(1306);
      frame_height_q <= CFG_W'(746);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (EW'(frame_width_q) < EW'(WIN)) begin
      eff_w = EW'(WIN);
    end else if (EW'(frame_width_q) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width_q);
    end
    eff_h    = (frame_height_q < ROW_W'(WIN)) ? ROW_W'(WIN) : frame_height_q;
    col_ext  = EW'(col_q);
    interior = (row_q >= ROW_W'(LROWS)) && (col_ext >= EW'(LROWS)) &&
               (col_ext < eff_w) && (row_q < eff_h);
    col_d = col_q + CW'(1);
    row_d = row_q;
    if ((EW + 1)'(col_ext) + (EW + 1)'(1) >= (EW + 1)'(eff_w)) begin
      col_d = '0;
      if (({1'b0, row_q} + 13'd1 >= {1'b0, eff_h}) || (row_q == ROW_W'(MAX_ROW))) begin
        row_d = '0;
      end else begin
        row_d = row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (en) begin
        va_q        <= in_valid_i;
        vb_q        <= va_q;
        vc_q        <= vb_q;
        out_valid_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q   <= pixel_i;
      addr_q  <= col_q;
      ins_a_q <= interior;
    end
    if (en && va_q) begin
      ins_b_q <= ins_a_q;
    end
    if (en && vb_q) begin
      ins_c_q <= ins_b_q;
    end
    if (en && vc_q) begin
      interior_q <= ins_c_q;
      dog_q      <= ins_c_q ? sat[DOG_W-1:0] : '0;
    end
  end

  always_comb begin
    for (int k = 0; k < LROWS; k++) begin
      col_vec[k] = rd_data[k*PIX_W +: PIX_W];
    end
    col_vec[LROWS] = pix_q;
    for (int k = 0; k < LROWS; k++) begin
      wr_data[k*PIX_W +: PIX_W] = col_vec[k+1];
    end
  end

  dogf_line_buffer #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW       (CW)
  ) u_line_buffer (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(col_q),
    .rd_data_o(rd_data),
    .wr_en_i  (en && va_q),
    .wr_addr_i(addr_q),
    .wr_data_i(wr_data)
  );

  assign cell_ctl.load  = en && va_q;
  assign cell_ctl.shift = en && vb_q;
  assign acc[0] = '0;

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    dogf_cell #(
      .COL(j)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (cell_ctl),
      .col_i (col_vec),
      .acc_i (acc[j]),
      .acc_o (acc[j+1])
    );
  end

  always_comb begin
    if (acc[WIN] > DOG_LIM) begin
      sat = DOG_LIM;
    end else if (acc[WIN] < -DOG_LIM) begin
      sat = -DOG_LIM;
    end else begin
      sat = acc[WIN];
    end
  end

  assign out_valid_o = out_valid_q;
  assign dog_value_o = dog_q;
  assign interior_o  = interior_q;

`ifndef NO_ASSERTIONS
  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !interior_o |-> dog_value_o == '0)
    else $error("edge result not zero");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> va_q)
    else $error("transfer did not enter pipeline");

  a_dog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dog_value_o <= DOG_W'(DOG_LIM)) && (dog_value_o >= -DOG_W'(DOG_LIM)))
    else $error("result out of range");
`endif

endmodule
`default_nettype wire

// ----- sv/dogf_line_buffer.sv -----
// dogf_line_buffer: line store of the filter, all buffered rows of one column
// in one word; depends on dogf_pkg
`default_nettype none
module dogf_line_buffer import dogf_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = 11
) (
  input  wire logic                   clk_i,
  input  wire logic                   rd_en_i,
  input  wire logic [AW-1:0]          rd_addr_i,
  output logic [LROWS*PIX_W-1:0]      rd_data_o,
  input  wire logic                   wr_en_i,
  input  wire logic [AW-1:0]          wr_addr_i,
  input  wire logic [LROWS*PIX_W-1:0] wr_data_i
);

  logic [LROWS*PIX_W-1:0] mem [MAX_WIDTH];
  logic [LROWS*PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ----- sv/dogf_cell.sv -----
// dogf_cell: one window column position, weighted column sum plus running sum
// handed to the next cell; depends on dogf_pkg
`default_nettype none
module dogf_cell import dogf_pkg::*; #(
  parameter int COL = 0
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cell_ctl_t               ctl_i,
  input  wire pix_vec_t                col_i,
  input  wire logic signed [ACC_W-1:0] acc_i,
  output logic signed [ACC_W-1:0]      acc_o
);

  logic signed [PROD_W-1:0] prod [WIN];
  logic signed [ACC_W-1:0]  cs_d, cs_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;

  for (genvar r = 0; r < WIN; r++) begin : g_tap
    localparam logic signed [COEF_W-1:0] W = dog_coef(r, COL);
    assign prod[r] = PROD_W'($signed({1'b0, col_i[r]})) * PROD_W'(W);
  end

  always_comb begin
    cs_d = '0;
    for (int r = 0; r < WIN; r++) begin
      cs_d = cs_d + ACC_W'(prod[r]);
    end
    acc_d = acc_i + cs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q  <= '0;
      acc_q <= '0;
    end else begin
      if (ctl_i.load) begin
        cs_q <= cs_d;
      end
      if (ctl_i.shift) begin
        acc_q <= acc_d;
      end
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for difference_of_gaussians_filter_unit
// depends on dogf_pkg and the unit; holds its own blur predictor in a scoreboard class
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import dogf_pkg::*;

  localparam int MAXW = 2048;
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    logic signed [DOG_W-1:0] dog;
    logic                    inner;
  } dog_result_t;

  class dog_scoreboard;
    logic [7:0] line_mem [LROWS*MAXW];
    logic [7:0] win [WIN][WIN];
    longint coef [KER+1][KER+1];
    int slot;
    int col_cnt;
    int row_cnt;
    int width;
    int height;
    int errors;
    dog_result_t pending [$];

    function new();
      longint e [31];
      longint gb [KER+1];
      longint gs [KER+1];
      longint sb;
      longint ss;
      longint ws;
      longint wb;
      foreach (e[i]) e[i] = 0;
      e[0] = 16777216; e[1] = 14378022; e[2] = 9049756; e[3] = 4183434;
      e[4] = 1420326; e[5] = 354161; e[6] = 64859; e[7] = 8724;
      e[8] = 862; e[9] = 63; e[10] = 3;
      sb = e[0];
      ss = e[0];
      for (int d = 1; d <= BIG_RADIUS; d++) sb += 2 * e[d];
      for (int d = 1; d <= SMALL_RADIUS; d++) ss += 2 * e[2*d];
      for (int d = 0; d <= KER; d++) begin
        gb[d] = ((e[d] << 24) + sb / 2) / sb;
        gs[d] = ((e[2*d] << 24) + ss / 2) / ss;
      end
      for (int a = 0; a <= KER; a++) begin
        for (int b = 0; b <= KER; b++) begin
          ws = 0;
          wb = 0;
          if (a <= SMALL_RADIUS && b <= SMALL_RADIUS)
            ws = (gs[a] * gs[b] + (64'd1 << (47 - COEF_FRAC_BITS))) >> (48 - COEF_FRAC_BITS);
          if (a <= BIG_RADIUS && b <= BIG_RADIUS)
            wb = (gb[a] * gb[b] + (64'd1 << (47 - COEF_FRAC_BITS))) >> (48 - COEF_FRAC_BITS);
          coef[a][b] = ws - wb;
        end
      end
      foreach (line_mem[i]) line_mem[i] = 0;
      foreach (win[i, j]) win[i][j] = 0;
      slot = 0;
      col_cnt = 0;
      row_cnt = 0;
      width = 1306;
      height = 746;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH) width = val;
      else if (idx == CFG_FRAME_HEIGHT) height = val;
    endfunction

    // accepted pixel transfer: shift line store and window, queue the result
    function void note_pixel(logic [7:0] pix);
      int w;
      int h;
      int c;
      logic [7:0] col [WIN];
      longint acc;
      longint lim;
      dog_result_t r;
      w = (width < WIN) ? WIN : (width > MAXW ? MAXW : width);
      h = (height < WIN) ? WIN : height;
      c = (col_cnt >= MAXW) ? MAXW - 1 : col_cnt;
      for (int k = 0; k < LROWS; k++) col[k] = line_mem[k*MAXW + c];
      col[LROWS] = pix;
      for (int k = 0; k < LROWS; k++) line_mem[k*MAXW + c] = col[k+1];
      for (int k = 0; k < WIN; k++) win[k][slot] = col[k];
      slot = (slot + 1) % WIN;
      r.inner = row_cnt >= LROWS && col_cnt >= LROWS && col_cnt < w && row_cnt < h;
      acc = 0;
      if (r.inner) begin
        for (int m = 0; m < WIN; m++) begin
          for (int n = 0; n < WIN; n++) begin
            acc += longint'(win[m][(slot + n) % WIN]) *
                   coef[m >= KER ? m - KER : KER - m][n >= KER ? n - KER : KER - n];
          end
        end
        lim = 255 << COEF_FRAC_BITS;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
      end
      r.dog = acc[DOG_W-1:0];
      pending.push_back(r);
      if (col_cnt + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1 >= h || row_cnt + 1 > MAX_ROW) ? 0 : row_cnt + 1;
      end else begin
        col_cnt++;
      end
    endfunction

    function void check_result(logic signed [DOG_W-1:0] dog, logic inner);
      dog_result_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result dog %0d interior %0d", $time, dog, inner);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (dog !== x.dog) begin
        $display("%0t: dog_value expected %0d actual %0d", $time, x.dog, dog);
        errors++;
      end
      if (inner !== x.inner) begin
        $display("%0t: interior expected %0d actual %0d", $time, x.inner, inner);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PIX_W-1:0] pixel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DOG_W-1:0] dog_value_o;
  logic interior_o;

  int send_idle = 0;
  int recv_stall = 0;
  dog_scoreboard sb = new();

  difference_of_gaussians_filter_unit uut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(dog_value_o, interior_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_pixel(logic [7:0] p);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic finish_frame();
    while (sb.col_cnt != 0 || sb.row_cnt != 0) send_pixel(rand_pixel());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(CFG_FRAME_WIDTH, 12'd32);
    write_reg(CFG_FRAME_HEIGHT, 12'd32);
    write_reg(CFG_SPARE_2, 12'hfff);
    write_reg(CFG_SPARE_3, 12'h5a5);

    // directed extremes and patterns
    for (int i = 0; i < 24; i++) begin
      case (i % 6)
        0: send_pixel(8'd0);
        1: send_pixel(8'd255);
        2: send_pixel(8'h55);
        3: send_pixel(8'haa);
        4: send_pixel(8'(1 << (i % 8)));
        default: send_pixel(8'(~(1 << (i % 8))));
      endcase
    end
    send_random(808);

    // interior rows under each idling mix
    send_idle = 77;
    send_random(64);
    send_idle = 0;
    recv_stall = 77;
    send_random(64);
    send_idle = 32;
    recv_stall = 32;
    finish_frame();
    drain();

    // shrink the frame mid-frame past the current column
    send_idle = 0;
    recv_stall = 0;
    send_random(60);
    drain();
    write_reg(CFG_FRAME_WIDTH, 12'd0);
    write_reg(CFG_FRAME_HEIGHT, 12'd4095);
    send_random(30);
    drain();

    // widest and shortest
    write_reg(CFG_FRAME_WIDTH, 12'd4095);
    write_reg(CFG_FRAME_HEIGHT, 12'd0);
    send_random(30);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/dogf_pkg.sv
sv/dogf_line_buffer.sv
sv/dogf_cell.sv
sv/difference_of_gaussians_filter_unit.sv
tb/tb.sv
